// ===== rtl/core/tlc_pkg.sv =====
// shared types, codes and constants of the token link controller
package tlc_pkg;

  localparam int HANDLE_BITS    = 8;
  localparam int OP_BITS        = 3;
  localparam int FRAME_BITS     = 3;
  localparam int KIND_BITS      = 3;
  localparam int MODE_BITS      = 2;
  localparam int PEND_BITS      = 3;
  localparam int ATT_BITS       = 8;
  localparam int TIMER_BITS     = 16;
  localparam int IDLE_BITS      = 17;
  localparam int BASE_BITS      = 15;
  localparam int LFSR_BITS      = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef logic [OP_BITS-1:0]        opcode_t;
  typedef logic [FRAME_BITS-1:0]     frame_t;
  typedef logic [KIND_BITS-1:0]      kind_t;
  typedef logic [MODE_BITS-1:0]      mode_t;
  typedef logic [PEND_BITS-1:0]      pend_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [HANDLE_BITS-1:0]    handle_t;

  localparam opcode_t OPC_TICK  = 3'd0;
  localparam opcode_t OPC_FRAME = 3'd1;
  localparam opcode_t OPC_BIND  = 3'd2;
  localparam opcode_t OPC_DATA  = 3'd3;
  localparam opcode_t OPC_PASS  = 3'd4;
  localparam opcode_t OPC_CLOSE = 3'd5;

  localparam frame_t FR_BIND  = 3'd0;
  localparam frame_t FR_ACK   = 3'd1;
  localparam frame_t FR_DATA  = 3'd2;
  localparam frame_t FR_PASS  = 3'd3;
  localparam frame_t FR_ALIVE = 3'd4;
  localparam frame_t FR_CLOSE = 3'd5;

  localparam kind_t K_SEND   = 3'd0;
  localparam kind_t K_READY  = 3'd1;
  localparam kind_t K_TOKEN  = 3'd2;
  localparam kind_t K_CLOSED = 3'd3;
  localparam kind_t K_DONE   = 3'd4;

  localparam mode_t M_NONE  = 2'd0;
  localparam mode_t M_WAIT  = 2'd1;
  localparam mode_t M_TOKEN = 2'd2;

  localparam pend_t P_NONE  = 3'd0;
  localparam pend_t P_BIND  = 3'd1;
  localparam pend_t P_DATA  = 3'd2;
  localparam pend_t P_PASS  = 3'd3;
  localparam pend_t P_CLOSE = 3'd4;
  localparam pend_t P_ALIVE = 3'd5;

  localparam cfg_index_t CFG_BIND_ATTEMPTS = 3'd0;
  localparam cfg_index_t CFG_ACK_ATTEMPTS  = 3'd1;
  localparam cfg_index_t CFG_LISTEN_TICKS  = 3'd2;
  localparam cfg_index_t CFG_LOSS_TICKS    = 3'd3;
  localparam cfg_index_t CFG_BACKOFF_BASE  = 3'd4;
  localparam cfg_index_t CFG_RANDOM_SEED   = 3'd5;

  localparam logic [ATT_BITS-1:0]   RST_BIND_ATTEMPTS = 8'd10;
  localparam logic [ATT_BITS-1:0]   RST_ACK_ATTEMPTS  = 8'd3;
  localparam logic [TIMER_BITS-1:0] RST_LISTEN_TICKS  = 16'd500;
  localparam logic [TIMER_BITS-1:0] RST_LOSS_TICKS    = 16'd5000;
  localparam logic [BASE_BITS-1:0]  RST_BACKOFF_BASE  = 15'd200;
  localparam logic [LFSR_BITS-1:0]  RST_RANDOM_SEED   = 16'd44257;
  localparam logic [LFSR_BITS-1:0]  LFSR_MASK         = 16'hB400;

  typedef logic [1:0] hsel_t;
  localparam hsel_t HS_NONE    = 2'd0;
  localparam hsel_t HS_PENDING = 2'd1;
  localparam hsel_t HS_INPUT   = 2'd2;

  typedef logic [1:0] att_act_t;
  localparam att_act_t ATT_KEEP  = 2'd0;
  localparam att_act_t ATT_ONE   = 2'd1;
  localparam att_act_t ATT_INC   = 2'd2;
  localparam att_act_t ATT_CLEAR = 2'd3;

  typedef logic [1:0] tmr_act_t;
  localparam tmr_act_t TMR_KEEP   = 2'd0;
  localparam tmr_act_t TMR_LISTEN = 2'd1;
  localparam tmr_act_t TMR_CLEAR  = 2'd2;
  localparam tmr_act_t TMR_DEC    = 2'd3;

  typedef logic [1:0] idle_act_t;
  localparam idle_act_t IDLE_KEEP  = 2'd0;
  localparam idle_act_t IDLE_INC   = 2'd1;
  localparam idle_act_t IDLE_CLEAR = 2'd2;

  typedef struct packed {
    kind_t  kind;
    frame_t frame;
    hsel_t  hsel;
    logic   success;
  } res_t;

  typedef struct packed {
    logic      mode_we;
    mode_t     mode;
    logic      pend_we;
    pend_t     pend;
    att_act_t  att;
    tmr_act_t  tmr;
    idle_act_t idle;
    logic      handle_load;
    logic      start_backoff;
  } upd_t;

  typedef struct packed {
    logic load_input;
    logic commit;
    upd_t upd;
    logic load_backoff;
    logic push;
    res_t res;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    frame_t  rx_type;
    mode_t   mode;
    pend_t   pend;
    logic    timer_le1;
    logic    idle_gt_loss;
    logic    idle_gt_half;
    logic    att_lt_bind;
    logic    att_lt_ack;
    logic    div_done;
    logic    out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/tlc_if.sv =====
// channel interfaces of the token link controller
interface tlc_item_if
  import tlc_pkg::*;
();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  frame_t  rx_type;
  handle_t payload_handle;

  modport source (output valid, output opcode, output rx_type, output payload_handle,
                  input ready);
  modport sink (input valid, input opcode, input rx_type, input payload_handle,
                output ready);
endinterface

interface tlc_result_if
  import tlc_pkg::*;
();
  logic    valid;
  logic    ready;
  kind_t   kind;
  frame_t  frame_type;
  handle_t out_handle;
  logic    success;
  logic    last;

  modport source (output valid, output kind, output frame_type, output out_handle,
                  output success, output last, input ready);
  modport sink (input valid, input kind, input frame_type, input out_handle,
                input success, input last, output ready);
endinterface

interface tlc_cfg_if
  import tlc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  cfg_index_t               index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/tlc_ctrl.sv =====
// controller state machine: event decisions and result sequencing
module tlc_ctrl
  import tlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  typedef struct packed {
    upd_t       upd;
    logic [1:0] nres;
    res_t       r0;
    res_t       r1;
  } plan_t;

  function automatic res_t mk(kind_t k, frame_t f, hsel_t h, logic s);
    res_t r;
    r.kind = k;
    r.frame = f;
    r.hsel = h;
    r.success = s;
    return r;
  endfunction

  function automatic frame_t pend_frame(pend_t op);
    frame_t f;
    case (op)
      P_DATA:  f = FR_DATA;
      P_PASS:  f = FR_PASS;
      P_CLOSE: f = FR_CLOSE;
      P_ALIVE: f = FR_ALIVE;
      default: f = FR_BIND;
    endcase
    return f;
  endfunction

  function automatic plan_t send_pending(plan_t p, pend_t op);
    plan_t q;
    q = p;
    q.nres = 2'd1;
    q.r0 = mk(K_SEND, pend_frame(op), (op == P_DATA) ? HS_PENDING : HS_NONE, 1'b0);
    if (op == P_BIND) begin
      q.upd.tmr = TMR_KEEP;
      q.upd.start_backoff = 1'b1;
    end else begin
      q.upd.tmr = TMR_LISTEN;
    end
    return q;
  endfunction

  function automatic plan_t start_op(plan_t p, pend_t op);
    plan_t q;
    q = p;
    q.upd.pend_we = 1'b1;
    q.upd.pend = op;
    q.upd.att = ATT_ONE;
    return send_pending(q, op);
  endfunction

  function automatic plan_t finish(plan_t p);
    plan_t q;
    q = p;
    q.upd.pend_we = 1'b1;
    q.upd.pend = P_NONE;
    q.upd.att = ATT_CLEAR;
    q.upd.tmr = TMR_CLEAR;
    return q;
  endfunction

  function automatic plan_t terminate(plan_t p);
    plan_t q;
    q = finish(p);
    q.upd.mode_we = 1'b1;
    q.upd.mode = M_NONE;
    return q;
  endfunction

  function automatic plan_t attempt_over(plan_t p, pend_t op, logic lt_bind, logic lt_ack);
    plan_t q;
    logic  lt;
    q = p;
    lt = (op == P_BIND) ? lt_bind : lt_ack;
    if (lt) begin
      q.upd.att = ATT_INC;
      q = send_pending(q, op);
    end else begin
      q = finish(q);
      q.nres = 2'd1;
      if (op == P_ALIVE || op == P_CLOSE) begin
        q.upd.mode_we = 1'b1;
        q.upd.mode = M_NONE;
        q.r0 = mk(K_CLOSED, FR_BIND, HS_NONE, 1'b0);
      end else begin
        q.r0 = mk(K_DONE, FR_BIND, HS_NONE, 1'b0);
      end
    end
    return q;
  endfunction

  logic [1:0] state, state_next;
  logic [1:0] nres;
  res_t       r0, r1, cur;
  logic       idx, is_last;
  plan_t      plan;

  // decision for the latched transaction
  always_comb begin
    plan = '0;
    unique case (status.opcode)
      OPC_TICK: begin
        plan.upd.idle = IDLE_INC;
        if (status.pend != P_NONE) begin
          if (status.timer_le1) begin
            plan.upd.tmr = TMR_CLEAR;
            plan = attempt_over(plan, status.pend, status.att_lt_bind, status.att_lt_ack);
          end else begin
            plan.upd.tmr = TMR_DEC;
          end
        end else if (status.mode == M_WAIT && status.idle_gt_loss) begin
          plan = terminate(plan);
          plan.nres = 2'd1;
          plan.r0 = mk(K_CLOSED, FR_BIND, HS_NONE, 1'b0);
        end else if (status.mode == M_TOKEN && status.idle_gt_half) begin
          plan = start_op(plan, P_ALIVE);
        end
      end
      OPC_FRAME: begin
        plan.upd.idle = IDLE_CLEAR;
        if (status.pend == P_BIND) begin
          if (status.rx_type == FR_ACK) begin
            plan = finish(plan);
            plan.upd.mode_we = 1'b1;
            plan.upd.mode = M_TOKEN;
            plan.nres = 2'd1;
            plan.r0 = mk(K_DONE, FR_BIND, HS_NONE, 1'b1);
          end else if (status.rx_type == FR_BIND) begin
            plan = finish(plan);
            plan.upd.mode_we = 1'b1;
            plan.upd.mode = M_WAIT;
            plan.nres = 2'd2;
            plan.r0 = mk(K_SEND, FR_ACK, HS_NONE, 1'b0);
            plan.r1 = mk(K_DONE, FR_BIND, HS_NONE, 1'b1);
          end else begin
            plan = attempt_over(plan, status.pend, status.att_lt_bind, status.att_lt_ack);
          end
        end else if (status.pend != P_NONE) begin
          if (status.rx_type != FR_ACK) begin
            plan = attempt_over(plan, status.pend, status.att_lt_bind, status.att_lt_ack);
          end else if (status.pend == P_CLOSE) begin
            plan = terminate(plan);
            plan.nres = 2'd1;
            plan.r0 = mk(K_CLOSED, FR_BIND, HS_NONE, 1'b0);
          end else if (status.pend == P_ALIVE) begin
            plan = finish(plan);
          end else begin
            plan = finish(plan);
            if (status.pend == P_PASS) begin
              plan.upd.mode_we = 1'b1;
              plan.upd.mode = M_WAIT;
            end
            plan.nres = 2'd1;
            plan.r0 = mk(K_DONE, FR_BIND, HS_NONE, 1'b1);
          end
        end else if (status.mode == M_WAIT) begin
          case (status.rx_type)
            FR_DATA: begin
              plan.nres = 2'd2;
              plan.r0 = mk(K_READY, FR_BIND, HS_INPUT, 1'b0);
              plan.r1 = mk(K_SEND, FR_ACK, HS_NONE, 1'b0);
            end
            FR_PASS: begin
              plan.upd.mode_we = 1'b1;
              plan.upd.mode = M_TOKEN;
              plan.nres = 2'd2;
              plan.r0 = mk(K_TOKEN, FR_BIND, HS_NONE, 1'b0);
              plan.r1 = mk(K_SEND, FR_ACK, HS_NONE, 1'b0);
            end
            FR_ALIVE: begin
              plan.nres = 2'd1;
              plan.r0 = mk(K_SEND, FR_ACK, HS_NONE, 1'b0);
            end
            FR_CLOSE: begin
              plan = terminate(plan);
              plan.nres = 2'd2;
              plan.r0 = mk(K_SEND, FR_ACK, HS_NONE, 1'b0);
              plan.r1 = mk(K_CLOSED, FR_BIND, HS_NONE, 1'b0);
            end
            default: begin
            end
          endcase
        end
      end
      OPC_BIND: begin
        if (status.mode != M_NONE || status.pend != P_NONE) begin
          plan.nres = 2'd1;
          plan.r0 = mk(K_DONE, FR_BIND, HS_NONE, 1'b0);
        end else begin
          plan.upd.idle = IDLE_CLEAR;
          plan = start_op(plan, P_BIND);
        end
      end
      OPC_DATA, OPC_PASS: begin
        if (status.mode != M_TOKEN || status.pend != P_NONE) begin
          plan.nres = 2'd1;
          plan.r0 = mk(K_DONE, FR_BIND, HS_NONE, 1'b0);
        end else begin
          plan.upd.handle_load = 1'b1;
          plan = start_op(plan, (status.opcode == OPC_DATA) ? P_DATA : P_PASS);
        end
      end
      OPC_CLOSE: begin
        if (status.mode == M_TOKEN && status.pend == P_NONE) begin
          plan = start_op(plan, P_CLOSE);
        end else begin
          plan = terminate(plan);
          if (status.pend == P_BIND || status.pend == P_DATA || status.pend == P_PASS) begin
            plan.nres = 2'd2;
            plan.r0 = mk(K_DONE, FR_BIND, HS_NONE, 1'b0);
            plan.r1 = mk(K_CLOSED, FR_BIND, HS_NONE, 1'b0);
          end else begin
            plan.nres = 2'd1;
            plan.r0 = mk(K_CLOSED, FR_BIND, HS_NONE, 1'b0);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign cur = idx ? r1 : r0;
  assign is_last = idx || (nres == 2'd1);

  always_comb begin
    cmd = '0;
    state_next = state;
    item_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load_input = item_valid;
        if (item_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.commit = 1'b1;
        cmd.upd = plan.upd;
        if (plan.upd.start_backoff) begin
          state_next = S_DIV;
        end else if (plan.nres == 2'd0) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.load_backoff = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.push = 1'b1;
          cmd.res = cur;
          cmd.last = is_last;
          if (is_last) begin
            state_next = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      nres <= plan.nres;
      r0 <= plan.r0;
      r1 <= plan.r1;
      idx <= 1'b0;
    end else if (cmd.push) begin
      idx <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/tlc_dpath.sv =====
// datapath: configuration, link state registers, backoff divider, output register
module tlc_dpath
  import tlc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  opcode_t                  item_opcode,
  input  frame_t                   item_rx_type,
  input  handle_t                  item_handle,
  input  logic                     cfg_we,
  input  cfg_index_t               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     out_ready,
  output logic                     out_valid,
  output kind_t                    out_kind,
  output frame_t                   out_frame_type,
  output handle_t                  out_handle,
  output logic                     out_success,
  output logic                     out_last
);

  logic [ATT_BITS-1:0]   bind_attempts, ack_attempts;
  logic [TIMER_BITS-1:0] listen_ticks, loss_ticks;
  logic [BASE_BITS-1:0]  backoff_base;

  opcode_t lat_opcode;
  frame_t  lat_rx_type;
  handle_t lat_handle;

  mode_t                 link_mode;
  pend_t                 pending_op;
  logic [ATT_BITS-1:0]   attempts_used;
  logic [TIMER_BITS-1:0] wait_timer;
  logic [IDLE_BITS-1:0]  idle_ticks;
  logic [LFSR_BITS-1:0]  lfsr_value;
  handle_t               pending_handle;

  logic [LFSR_BITS-1:0] dividend;
  logic [BASE_BITS-1:0] rem;
  logic [3:0]           div_count;
  logic                 div_busy;

  logic [IDLE_BITS-1:0]  idle_inc;
  logic [ATT_BITS-1:0]   bind_lim, ack_lim;
  logic [LFSR_BITS-1:0]  lfsr_step, seed_load;
  logic [BASE_BITS:0]    trial;
  logic                  trial_ge;
  logic [BASE_BITS-1:0]  rem_next;
  logic [TIMER_BITS-1:0] backoff_val;
  handle_t               sel_handle;
  logic                  out_free;

  assign idle_inc = (idle_ticks == '1) ? idle_ticks : idle_ticks + IDLE_BITS'(1);
  assign bind_lim = (bind_attempts == '0) ? ATT_BITS'(1) : bind_attempts;
  assign ack_lim = (ack_attempts == '0) ? ATT_BITS'(1) : ack_attempts;
  assign lfsr_step = {1'b0, lfsr_value[LFSR_BITS-1:1]} ^ (lfsr_value[0] ? LFSR_MASK : '0);
  assign seed_load = (cfg_data == '0) ? LFSR_BITS'(1) : cfg_data;

  // one restoring step per cycle
  assign trial = {rem, dividend[LFSR_BITS-1]};
  assign trial_ge = (trial >= {1'b0, backoff_base});
  assign rem_next = trial_ge ? BASE_BITS'(trial - {1'b0, backoff_base}) : trial[BASE_BITS-1:0];
  // zero base gives no wait
  assign backoff_val = (backoff_base == '0) ? '0 : {1'b0, backoff_base} + {1'b0, rem};

  assign out_free = !out_valid || out_ready;

  always_comb begin
    status.opcode = lat_opcode;
    status.rx_type = lat_rx_type;
    status.mode = link_mode;
    status.pend = pending_op;
    status.timer_le1 = (wait_timer <= TIMER_BITS'(1));
    status.idle_gt_loss = (idle_inc > {1'b0, loss_ticks});
    status.idle_gt_half = (idle_inc > {2'b00, loss_ticks[TIMER_BITS-1:1]});
    status.att_lt_bind = (attempts_used < bind_lim);
    status.att_lt_ack = (attempts_used < ack_lim);
    status.div_done = !div_busy;
    status.out_free = out_free;
  end

  always_comb begin
    case (cmd.res.hsel)
      HS_PENDING: sel_handle = pending_handle;
      HS_INPUT:   sel_handle = lat_handle;
      default:    sel_handle = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bind_attempts <= RST_BIND_ATTEMPTS;
      ack_attempts <= RST_ACK_ATTEMPTS;
      listen_ticks <= RST_LISTEN_TICKS;
      loss_ticks <= RST_LOSS_TICKS;
      backoff_base <= RST_BACKOFF_BASE;
      link_mode <= M_NONE;
      pending_op <= P_NONE;
      attempts_used <= '0;
      wait_timer <= '0;
      idle_ticks <= '0;
      lfsr_value <= RST_RANDOM_SEED;
      pending_handle <= '0;
      div_busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BIND_ATTEMPTS: bind_attempts <= cfg_data[ATT_BITS-1:0];
          CFG_ACK_ATTEMPTS:  ack_attempts <= cfg_data[ATT_BITS-1:0];
          CFG_LISTEN_TICKS:  listen_ticks <= cfg_data[TIMER_BITS-1:0];
          CFG_LOSS_TICKS:    loss_ticks <= cfg_data[TIMER_BITS-1:0];
          CFG_BACKOFF_BASE:  backoff_base <= cfg_data[BASE_BITS-1:0];
          CFG_RANDOM_SEED:   lfsr_value <= seed_load;
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        if (cmd.upd.mode_we) begin
          link_mode <= cmd.upd.mode;
        end
        if (cmd.upd.pend_we) begin
          pending_op <= cmd.upd.pend;
        end
        case (cmd.upd.att)
          ATT_ONE:   attempts_used <= ATT_BITS'(1);
          ATT_INC:   attempts_used <= attempts_used + ATT_BITS'(1);
          ATT_CLEAR: attempts_used <= '0;
          default:   attempts_used <= attempts_used;
        endcase
        case (cmd.upd.tmr)
          TMR_LISTEN: wait_timer <= listen_ticks;
          TMR_CLEAR:  wait_timer <= '0;
          TMR_DEC:    wait_timer <= wait_timer - TIMER_BITS'(1);
          default:    wait_timer <= wait_timer;
        endcase
        case (cmd.upd.idle)
          IDLE_INC:   idle_ticks <= idle_inc;
          IDLE_CLEAR: idle_ticks <= '0;
          default:    idle_ticks <= idle_ticks;
        endcase
        if (cmd.upd.handle_load) begin
          pending_handle <= (lat_opcode == OPC_DATA) ? lat_handle : '0;
        end
        if (cmd.upd.start_backoff) begin
          lfsr_value <= lfsr_step;
          div_busy <= 1'b1;
        end
      end else if (div_busy && div_count == '1) begin
        div_busy <= 1'b0;
      end
      if (cmd.load_backoff) begin
        wait_timer <= backoff_val;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      lat_opcode <= item_opcode;
      lat_rx_type <= item_rx_type;
      lat_handle <= item_handle;
    end
    if (cmd.commit && cmd.upd.start_backoff) begin
      dividend <= lfsr_step;
      rem <= '0;
      div_count <= '0;
    end else if (div_busy) begin
      dividend <= {dividend[LFSR_BITS-2:0], 1'b0};
      rem <= rem_next;
      div_count <= div_count + 4'd1;
    end
    if (cmd.push) begin
      out_kind <= cmd.res.kind;
      out_frame_type <= cmd.res.frame;
      out_handle <= sel_handle;
      out_success <= cmd.res.success;
      out_last <= cmd.last;
    end
  end

endmodule

// ===== rtl/core/token_link_controller_core.sv =====
// token link controller top level: controller and datapath joined by command and status
// one transaction at a time: the next transaction is taken only after all n results
// (0 to 2) of the last one have been pushed to the output register
// sending a bind frame also waits for the bit-serial backoff remainder
// synchronous reset loads default configuration, clears link state and seeds the lfsr
module token_link_controller_core
  import tlc_pkg::*;
(
  input logic          clk,
  input logic          rst,
  tlc_item_if.sink     item,
  tlc_result_if.source result,
  tlc_cfg_if.sink      cfg
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       item_ready;

  assign item.ready = item_ready;
  assign cfg.ready = 1'b1;

  tlc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  tlc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .item_opcode    (item.opcode),
    .item_rx_type   (item.rx_type),
    .item_handle    (item.payload_handle),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_ready      (result.ready),
    .out_valid      (result.valid),
    .out_kind       (result.kind),
    .out_frame_type (result.frame_type),
    .out_handle     (result.out_handle),
    .out_success    (result.success),
    .out_last       (result.last)
  );

endmodule

// ===== tb/tb_token_link_controller_core.sv =====
// self-checking testbench of the token link controller core with a built-in link predictor
module tb_token_link_controller_core;
  import tlc_pkg::*;

  localparam opcode_t OPC_SPARE6 = 3'd6;
  localparam opcode_t OPC_SPARE7 = 3'd7;
  localparam frame_t FR_SPARE7 = 3'd7;
  localparam frame_t FRAME_NONE = '0;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    opcode_t op;
    frame_t rx;
    handle_t handle;
  } link_input_t;

  typedef struct packed {
    kind_t kind;
    frame_t frame;
    handle_t handle;
    logic success;
    logic last;
  } link_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tlc_item_if item_ch();
  tlc_result_if res_ch();
  tlc_cfg_if cfg_ch();

  token_link_controller_core dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(res_ch),
    .cfg(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register copies
  logic [ATT_BITS-1:0] reg_bind_tries, reg_ack_tries;
  logic [TIMER_BITS-1:0] reg_listen, reg_loss;
  logic [BASE_BITS-1:0] reg_base;

  // link state copies
  mode_t st_mode;
  pend_t st_pend;
  logic [ATT_BITS-1:0] st_tries;
  logic [TIMER_BITS-1:0] st_timer;
  logic [IDLE_BITS-1:0] st_idle;
  logic [LFSR_BITS-1:0] st_lfsr;
  handle_t st_handle;

  link_input_t link_q[$];
  link_result_t outputs_due[$];

  int queued_count = 0;
  int items_offered = 0;
  int items_accepted = 0;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int rx_hold_left = 0;
  bit rx_hold_req = 1'b0;
  bit item_taken = 1'b0;
  link_input_t next_input;
  link_result_t got_result, want_result;

  function automatic void emit_result(kind_t k, frame_t f, handle_t h, logic ok);
    link_result_t r;
    r = '{kind: k, frame: f, handle: h, success: ok, last: 1'b0};
    outputs_due.push_back(r);
  endfunction

  function automatic logic [TIMER_BITS-1:0] draw_backoff();
    logic lsb;
    int b;
    int v;
    lsb = st_lfsr[0];
    st_lfsr = st_lfsr >> 1;
    if (lsb) st_lfsr = st_lfsr ^ LFSR_MASK;
    b = reg_base;
    v = st_lfsr;
    if (b == 0) return '0;
    return TIMER_BITS'(b + (v % b));
  endfunction

  function automatic void drop_link();
    st_mode = M_NONE;
    st_pend = P_NONE;
    st_tries = '0;
    st_timer = '0;
  endfunction

  function automatic void clear_op();
    st_pend = P_NONE;
    st_tries = '0;
    st_timer = '0;
  endfunction

  function automatic void send_pending_frame();
    frame_t f;
    handle_t h;
    case (st_pend)
      P_DATA: f = FR_DATA;
      P_PASS: f = FR_PASS;
      P_CLOSE: f = FR_CLOSE;
      P_ALIVE: f = FR_ALIVE;
      default: f = FR_BIND;
    endcase
    h = (st_pend == P_DATA) ? st_handle : '0;
    st_timer = (st_pend == P_BIND) ? draw_backoff() : reg_listen;
    emit_result(K_SEND, f, h, 1'b0);
  endfunction

  function automatic void begin_op(pend_t op);
    st_pend = op;
    st_tries = 8'd1;
    send_pending_frame();
  endfunction

  function automatic void attempt_ended();
    int limit;
    pend_t op;
    limit = (st_pend == P_BIND) ? int'(reg_bind_tries) : int'(reg_ack_tries);
    if (limit == 0) limit = 1;
    if (int'(st_tries) < limit) begin
      st_tries = st_tries + 8'd1;
      send_pending_frame();
      return;
    end
    op = st_pend;
    clear_op();
    if (op == P_ALIVE || op == P_CLOSE) begin
      drop_link();
      emit_result(K_CLOSED, FRAME_NONE, '0, 1'b0);
    end else begin
      emit_result(K_DONE, FRAME_NONE, '0, 1'b0);
    end
  endfunction

  function automatic void frame_event(frame_t rx, handle_t h);
    pend_t op;
    st_idle = '0;
    if (st_pend == P_BIND) begin
      if (rx == FR_ACK) begin
        clear_op();
        st_mode = M_TOKEN;
        emit_result(K_DONE, FRAME_NONE, '0, 1'b1);
      end else if (rx == FR_BIND) begin
        clear_op();
        st_mode = M_WAIT;
        emit_result(K_SEND, FR_ACK, '0, 1'b0);
        emit_result(K_DONE, FRAME_NONE, '0, 1'b1);
      end else begin
        attempt_ended();
      end
      return;
    end
    if (st_pend != P_NONE) begin
      if (rx != FR_ACK) begin
        attempt_ended();
        return;
      end
      op = st_pend;
      clear_op();
      if (op == P_CLOSE) begin
        drop_link();
        emit_result(K_CLOSED, FRAME_NONE, '0, 1'b0);
      end else if (op != P_ALIVE) begin
        if (op == P_PASS) st_mode = M_WAIT;
        emit_result(K_DONE, FRAME_NONE, '0, 1'b1);
      end
      return;
    end
    if (st_mode != M_WAIT) return;
    case (rx)
      FR_DATA: begin
        emit_result(K_READY, FRAME_NONE, h, 1'b0);
        emit_result(K_SEND, FR_ACK, '0, 1'b0);
      end
      FR_PASS: begin
        st_mode = M_TOKEN;
        emit_result(K_TOKEN, FRAME_NONE, '0, 1'b0);
        emit_result(K_SEND, FR_ACK, '0, 1'b0);
      end
      FR_ALIVE: emit_result(K_SEND, FR_ACK, '0, 1'b0);
      FR_CLOSE: begin
        drop_link();
        emit_result(K_SEND, FR_ACK, '0, 1'b0);
        emit_result(K_CLOSED, FRAME_NONE, '0, 1'b0);
      end
      default: ;
    endcase
  endfunction

  function automatic void tick_event();
    if (st_idle != '1) st_idle = st_idle + 1'b1;
    if (st_pend != P_NONE) begin
      if (st_timer <= 1) begin
        st_timer = '0;
        attempt_ended();
      end else begin
        st_timer = st_timer - 1'b1;
      end
    end else if (st_mode == M_WAIT && st_idle > reg_loss) begin
      drop_link();
      emit_result(K_CLOSED, FRAME_NONE, '0, 1'b0);
    end else if (st_mode == M_TOKEN && st_idle > (reg_loss >> 1)) begin
      begin_op(P_ALIVE);
    end
  endfunction

  function automatic void close_cmd();
    if (st_mode == M_TOKEN && st_pend == P_NONE) begin
      begin_op(P_CLOSE);
      return;
    end
    if (st_pend == P_BIND || st_pend == P_DATA || st_pend == P_PASS)
      emit_result(K_DONE, FRAME_NONE, '0, 1'b0);
    drop_link();
    emit_result(K_CLOSED, FRAME_NONE, '0, 1'b0);
  endfunction

  function automatic void predict_link(link_input_t in);
    int first;
    link_result_t tail;
    first = outputs_due.size();
    case (in.op)
      OPC_TICK: tick_event();
      OPC_FRAME: frame_event(in.rx, in.handle);
      OPC_BIND: begin
        if (st_mode != M_NONE || st_pend != P_NONE) begin
          emit_result(K_DONE, FRAME_NONE, '0, 1'b0);
        end else begin
          st_idle = '0;
          begin_op(P_BIND);
        end
      end
      OPC_DATA, OPC_PASS: begin
        if (st_mode != M_TOKEN || st_pend != P_NONE) begin
          emit_result(K_DONE, FRAME_NONE, '0, 1'b0);
        end else begin
          st_handle = (in.op == OPC_DATA) ? in.handle : '0;
          begin_op((in.op == OPC_DATA) ? P_DATA : P_PASS);
        end
      end
      OPC_CLOSE: close_cmd();
      default: ;
    endcase
    if (outputs_due.size() > first) begin
      tail = outputs_due.pop_back();
      tail.last = 1'b1;
      outputs_due.push_back(tail);
    end
  endfunction

  function automatic void reset_link_model();
    reg_bind_tries = RST_BIND_ATTEMPTS;
    reg_ack_tries = RST_ACK_ATTEMPTS;
    reg_listen = RST_LISTEN_TICKS;
    reg_loss = RST_LOSS_TICKS;
    reg_base = RST_BACKOFF_BASE;
    st_lfsr = RST_RANDOM_SEED;
    st_handle = '0;
    st_idle = '0;
    drop_link();
  endfunction

  function automatic void write_model_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      CFG_BIND_ATTEMPTS: reg_bind_tries = val[ATT_BITS-1:0];
      CFG_ACK_ATTEMPTS: reg_ack_tries = val[ATT_BITS-1:0];
      CFG_LISTEN_TICKS: reg_listen = val;
      CFG_LOSS_TICKS: reg_loss = val;
      CFG_BACKOFF_BASE: reg_base = val[BASE_BITS-1:0];
      CFG_RANDOM_SEED: st_lfsr = (val == '0) ? LFSR_BITS'(1) : val;
      default: ;
    endcase
  endfunction

  function automatic void report_failure(string what, link_result_t want, link_result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch (%s): expected kind=%0d frame=%0d handle=%0d ok=%0d last=%0d,",
               what, want.kind, want.frame, want.handle, want.success, want.last,
               " got kind=%0d frame=%0d handle=%0d ok=%0d last=%0d",
               got.kind, got.frame, got.handle, got.success, got.last);
  endfunction

  // monitor
  always @(posedge clk) begin
    item_taken = !rst && item_ch.valid && item_ch.ready;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got_result = '{kind: res_ch.kind, frame: res_ch.frame_type, handle: res_ch.out_handle,
                     success: res_ch.success, last: res_ch.last};
      if (outputs_due.size() == 0) begin
        report_failure("no result expected", '0, got_result);
      end else begin
        want_result = outputs_due.pop_front();
        if (got_result.kind !== want_result.kind || got_result.frame !== want_result.frame ||
            got_result.handle !== want_result.handle ||
            got_result.success !== want_result.success || got_result.last !== want_result.last)
          report_failure("wrong field", want_result, got_result);
      end
    end
    if (item_taken) begin
      items_accepted++;
      predict_link('{op: item_ch.opcode, rx: item_ch.rx_type, handle: item_ch.payload_handle});
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_taken) begin
      if (link_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_input = link_q.pop_front();
        items_offered++;
        item_ch.valid <= 1'b1;
        item_ch.opcode <= next_input.op;
        item_ch.rx_type <= next_input.rx;
        item_ch.payload_handle <= next_input.handle;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off in phase 6
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = 400;
      rx_hold_req = 1'b0;
    end
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic handle_t rand_handle();
    return handle_t'($urandom_range(255));
  endfunction

  function automatic void queue_item(opcode_t op, frame_t rx, handle_t h);
    link_q.push_back('{op: op, rx: rx, handle: h});
    queued_count++;
  endfunction

  function automatic void queue_frame(frame_t rx);
    queue_item(OPC_FRAME, rx, rand_handle());
  endfunction

  function automatic void queue_ticks(int n);
    repeat (n) queue_item(OPC_TICK, frame_t'($urandom_range(7)), rand_handle());
  endfunction

  function automatic void queue_noise();
    queue_item(opcode_t'($urandom_range(7)), frame_t'($urandom_range(7)), rand_handle());
  endfunction

  // peer answer to a frame of ours: mostly an ack, sometimes a stray frame or silence
  function automatic bit queue_answer();
    int r;
    r = $urandom_range(99);
    if (r < 80) begin
      queue_frame(FR_ACK);
      return 1'b1;
    end
    if (r < 92) queue_frame(frame_t'($urandom_range(7)));
    return 1'b0;
  endfunction

  function automatic mode_t queue_bind(int short_ticks);
    int r;
    queue_item(OPC_BIND, frame_t'($urandom_range(7)), rand_handle());
    queue_ticks($urandom_range(short_ticks));
    r = $urandom_range(99);
    if (r < 50) begin
      queue_frame(FR_ACK);
      return M_TOKEN;
    end
    if (r < 90) begin
      queue_frame(FR_BIND);
      return M_WAIT;
    end
    return M_NONE;
  endfunction

  function automatic void queue_session(int short_ticks, int long_ticks);
    int r;
    mode_t side;
    queue_item(OPC_CLOSE, frame_t'($urandom_range(7)), rand_handle());
    queue_frame(FR_ACK);
    side = queue_bind(short_ticks);
    repeat ($urandom_range(3, 10)) begin
      r = $urandom_range(99);
      if (r < 8) begin
        queue_noise();
      end else if (r < 16) begin
        queue_ticks($urandom_range(1, long_ticks));
      end else if (side == M_TOKEN) begin
        r = $urandom_range(99);
        if (r < 45) begin
          queue_item(OPC_DATA, frame_t'($urandom_range(7)), rand_handle());
          queue_ticks($urandom_range(short_ticks));
          void'(queue_answer());
        end else if (r < 70) begin
          queue_item(OPC_PASS, frame_t'($urandom_range(7)), rand_handle());
          queue_ticks($urandom_range(short_ticks));
          if (queue_answer()) side = M_WAIT;
        end else if (r < 80) begin
          queue_item(OPC_CLOSE, frame_t'($urandom_range(7)), rand_handle());
          void'(queue_answer());
          side = M_NONE;
        end else begin
          // long silence, so the keep-alive goes out
          queue_ticks(long_ticks);
          void'(queue_answer());
        end
      end else if (side == M_WAIT) begin
        r = $urandom_range(99);
        if (r < 35) begin
          queue_frame(FR_DATA);
        end else if (r < 55) begin
          queue_frame(FR_ALIVE);
        end else if (r < 75) begin
          queue_frame(FR_PASS);
          side = M_TOKEN;
        end else if (r < 85) begin
          queue_frame(FR_CLOSE);
          side = M_NONE;
        end else begin
          queue_frame(frame_t'($urandom_range(7)));
        end
      end else begin
        side = queue_bind(short_ticks);
      end
    end
  endfunction

  task automatic write_reg(input cfg_index_t idx, input int val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= CFG_DATA_BITS'(val);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    write_model_reg(idx, CFG_DATA_BITS'(val));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_link_regs(input int binds, input int acks, input int listen,
                               input int loss, input int base, input int seed);
    write_reg(CFG_BIND_ATTEMPTS, binds);
    write_reg(CFG_ACK_ATTEMPTS, acks);
    write_reg(CFG_LISTEN_TICKS, listen);
    write_reg(CFG_LOSS_TICKS, loss);
    write_reg(CFG_BACKOFF_BASE, base);
    write_reg(CFG_RANDOM_SEED, seed);
  endtask

  task automatic set_idling(input int sel);
    case (sel)
      1: begin send_idle_pct = 69; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 69; end
      3: begin send_idle_pct = 37; recv_stall_pct = 37; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  // sender pauses until every outstanding result is back, then the block drains
  task automatic settle();
    while (link_q.size() != 0 || items_offered != items_accepted || outputs_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase;
    int target;
    int short_ticks;
    int long_ticks;
    int listen;
    int loss;
    int base;
    item_ch.valid = 1'b0;
    item_ch.opcode = OPC_TICK;
    item_ch.rx_type = FR_BIND;
    item_ch.payload_handle = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_BIND_ATTEMPTS;
    cfg_ch.data = '0;
    reset_link_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pass on the reset settings
    set_idling(0);
    queue_item(OPC_TICK, FR_BIND, 8'h00);
    queue_item(OPC_DATA, FR_DATA, 8'h5a);
    queue_item(OPC_PASS, FR_PASS, 8'h00);
    queue_item(OPC_FRAME, FR_ACK, 8'h00);
    queue_item(OPC_CLOSE, FR_CLOSE, 8'h00);
    queue_item(OPC_SPARE6, FR_SPARE7, 8'hff);
    queue_item(OPC_SPARE7, FR_ALIVE, 8'h81);
    queue_item(OPC_BIND, FR_BIND, 8'h00);
    queue_item(OPC_BIND, FR_BIND, 8'h00);
    queue_item(OPC_FRAME, FR_DATA, 8'hff);
    queue_item(OPC_FRAME, FR_ACK, 8'h00);
    queue_item(OPC_DATA, FR_BIND, 8'hff);
    queue_item(OPC_FRAME, FR_SPARE7, 8'h00);
    queue_item(OPC_FRAME, FR_ACK, 8'h00);
    queue_item(OPC_DATA, FR_BIND, 8'h00);
    queue_item(OPC_FRAME, FR_ACK, 8'h00);
    queue_item(OPC_PASS, FR_BIND, 8'h00);
    queue_item(OPC_FRAME, FR_ACK, 8'h00);
    queue_item(OPC_FRAME, FR_DATA, 8'ha5);
    queue_item(OPC_FRAME, FR_ALIVE, 8'h00);
    queue_item(OPC_FRAME, FR_BIND, 8'h00);
    queue_item(OPC_FRAME, FR_PASS, 8'h00);
    queue_item(OPC_CLOSE, FR_BIND, 8'h00);
    queue_item(OPC_FRAME, FR_ACK, 8'h00);
    queue_item(OPC_BIND, FR_BIND, 8'h00);
    queue_item(OPC_FRAME, FR_BIND, 8'h00);
    queue_item(OPC_FRAME, FR_CLOSE, 8'h00);
    queue_item(OPC_BIND, FR_BIND, 8'h00);
    queue_item(OPC_CLOSE, FR_BIND, 8'h00);

    for (phase = 0; phase < 12; phase++) begin
      settle();
      case (phase)
        1: begin
          set_link_regs(1, 1, 1, 2, 1, 1);
          short_ticks = 3;
          long_ticks = 4;
        end
        2: begin
          set_link_regs(0, 0, 0, 0, 0, 0);
          short_ticks = 2;
          long_ticks = 3;
        end
        3: begin
          set_link_regs(255, 255, 65535, 65535, 32767, 65535);
          short_ticks = 3;
          long_ticks = 3;
        end
        default: begin
          listen = $urandom_range(1, 6);
          loss = $urandom_range(2, 40);
          base = $urandom_range(1, 5);
          set_link_regs($urandom_range(1, 6), $urandom_range(1, 4), listen, loss, base,
                        $urandom_range(1, 65535));
          short_ticks = listen + 2 * base;
          long_ticks = loss + 2;
        end
      endcase
      set_idling(phase % 4);
      if (phase == 6) begin
        // receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        rx_hold_req = 1'b1;
      end
      target = queued_count + ((phase == 3) ? 40 : 75);
      while (queued_count < target) queue_session(short_ticks, long_ticks);
    end

    settle();
    if (fail_count == 0) begin
      $display("** token_link_controller_core: PASSED **");
    end else begin
      $display("** token_link_controller_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** token_link_controller_core: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tlc_pkg.sv
rtl/core/tlc_if.sv
rtl/core/tlc_ctrl.sv
rtl/core/tlc_dpath.sv
rtl/core/token_link_controller_core.sv
tb/tb_token_link_controller_core.sv
